/* sv/hsa_pkg.sv */
// Shared types, constants and helper functions of the heading sector announcer.
package hsa_pkg;

  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned LEADER_BITS = 16;
  localparam int unsigned HEAD_BITS   = 12;
  localparam int unsigned DELTA_BITS  = 11;
  localparam int unsigned SCALED_BITS = 18;
  localparam int unsigned ADDR_BITS   = 5;

  localparam logic [HEAD_BITS-1:0]  FULL_TURN   = 12'd3600;
  localparam logic [HEAD_BITS-1:0]  HALF_TURN   = 12'd1800;
  localparam logic [HEAD_BITS-1:0]  SECTOR_SPAN = 12'd450;
  localparam logic [HEAD_BITS-1:0]  SECTOR_HALF = 12'd225;
  localparam logic [SCALED_BITS-1:0] RATE_SCALE = 18'd100;

  localparam logic [2:0] REASON_NONE    = 3'd0;
  localparam logic [2:0] REASON_STOPPED = 3'd1;
  localparam logic [2:0] REASON_TURNING = 3'd2;
  localparam logic [2:0] REASON_SETTLED = 3'd3;
  localparam logic [2:0] REASON_FACING  = 3'd4;

  localparam logic [2:0] REG_ROTATE_DPS = 3'd0;
  localparam logic [2:0] REG_MAX_TURN   = 3'd1;
  localparam logic [2:0] REG_QUIET      = 3'd2;
  localparam logic [2:0] REG_MIN_GAP    = 3'd3;
  localparam logic [2:0] REG_SETTLE     = 3'd4;
  localparam logic [2:0] REG_HYST       = 3'd5;

  typedef logic [TIME_BITS-1:0] tstamp_t;

  typedef struct packed {
    logic [11:0] rotate_threshold_dps;
    logic [12:0] max_turn_dps;
    logic [15:0] quiet_ms;
    logic [15:0] min_announce_interval_ms;
    logic [15:0] settle_ms;
    logic [7:0]  hysteresis_tenths;
  } cfg_t;

  typedef struct packed {
    logic                   kind;
    logic                   heading_valid;
    logic [HEAD_BITS-1:0]   heading;
    tstamp_t                time_ms;
    logic                   cinematic_active;
    logic                   auto_orient_active;
    logic [LEADER_BITS-1:0] leader_id;
    logic [15:0]            dedup_window_ms;
  } item_t;

  typedef struct packed {
    logic dt_nonzero;
    logic jump;
    logic rate_high;
  } rate_t;

  function automatic logic [2:0] sector_of(input logic [HEAD_BITS-1:0] h);
    logic [2:0] s;
    s = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (h >= HEAD_BITS'(i * 450 - 225)) begin
        s = 3'(i);
      end
    end
    if (h >= HEAD_BITS'(8 * 450 - 225)) begin
      s = 3'd0;
    end
    return s;
  endfunction

  function automatic logic [HEAD_BITS-1:0] sector_center(input logic [2:0] s);
    return HEAD_BITS'({9'd0, s} * SECTOR_SPAN);
  endfunction

  // Shortest angular distance between two headings, in tenths.
  function automatic logic [DELTA_BITS-1:0] abs_delta(input logic [HEAD_BITS-1:0] a,
                                                      input logic [HEAD_BITS-1:0] b);
    logic [HEAD_BITS-1:0] e;
    e = (a >= b) ? (a - b) : (b - a);
    if (e > HALF_TURN) begin
      return DELTA_BITS'(FULL_TURN - e);
    end
    return DELTA_BITS'(e);
  endfunction

endpackage

/* sv/heading_sector_announcer_top.sv */
// Top level of the heading sector announcer: input register, tracking core, registers.
//
//   Channel   Handshake                        Payload
//   input     in_valid_i / in_ready_o          kind .. dedup_window_ms
//   result    out_valid_o / out_ready_i        speak, sector, reason
//   config    psel, penable, pwrite / pready   paddr, pwdata, prdata
//
// One item is accepted per cycle while the result register is free or being taken; its result
// passes the input register and then the result register. The state update loop is combinational.
// Reset clears the tracking state and loads the register defaults; no clearing pass.
// A stalled result holds in the result register while one more item waits at the input.
module heading_sector_announcer_top
  import hsa_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   kind_i,
  input  logic                   heading_valid_i,
  input  logic [HEAD_BITS-1:0]   heading_i,
  input  logic [TIME_BITS-1:0]   time_ms_i,
  input  logic                   cinematic_active_i,
  input  logic                   auto_orient_active_i,
  input  logic [LEADER_BITS-1:0] leader_id_i,
  input  logic [15:0]            dedup_window_ms_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   speak_o,
  output logic [2:0]             sector_o,
  output logic [2:0]             reason_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_BITS-1:0]   paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cfg_t  cfg;
  item_t item_q;
  logic  item_valid_q;
  logic  step;

  assign step       = item_valid_q & (~out_valid_o | out_ready_i);
  assign in_ready_o = ~item_valid_q | step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.kind               <= kind_i;
      item_q.heading_valid      <= heading_valid_i;
      item_q.heading            <= heading_i;
      item_q.time_ms            <= time_ms_i;
      item_q.cinematic_active   <= cinematic_active_i;
      item_q.auto_orient_active <= auto_orient_active_i;
      item_q.leader_id          <= leader_id_i;
      item_q.dedup_window_ms    <= dedup_window_ms_i;
    end
  end

  hsa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hsa_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item_q),
    .cfg_i       (cfg),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .speak_o     (speak_o),
    .sector_o    (sector_o),
    .reason_o    (reason_o)
  );

  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !speak_o) |-> (sector_o == 3'd0 && reason_o == REASON_NONE))
    else $error("Silent result carries a sector or reason.");

  a_speak_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (speak_o == (reason_o != REASON_NONE)))
    else $error("Announce flag and reason disagree.");

  a_reason_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reason_o <= REASON_FACING))
    else $error("Reason code out of range.");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_q && out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("Input taken while both stages are full and stalled.");

endmodule

/* sv/hsa_cfg.sv */
// Configuration register file behind the APB-style port.
module hsa_cfg
  import hsa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[4:2])
        REG_ROTATE_DPS: cfg_d.rotate_threshold_dps     = pwdata[11:0];
        REG_MAX_TURN:   cfg_d.max_turn_dps             = pwdata[12:0];
        REG_QUIET:      cfg_d.quiet_ms                 = pwdata[15:0];
        REG_MIN_GAP:    cfg_d.min_announce_interval_ms = pwdata[15:0];
        REG_SETTLE:     cfg_d.settle_ms                = pwdata[15:0];
        REG_HYST:       cfg_d.hysteresis_tenths        = pwdata[7:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_ROTATE_DPS: prdata = {20'd0, cfg_q.rotate_threshold_dps};
      REG_MAX_TURN:   prdata = {19'd0, cfg_q.max_turn_dps};
      REG_QUIET:      prdata = {16'd0, cfg_q.quiet_ms};
      REG_MIN_GAP:    prdata = {16'd0, cfg_q.min_announce_interval_ms};
      REG_SETTLE:     prdata = {16'd0, cfg_q.settle_ms};
      REG_HYST:       prdata = {24'd0, cfg_q.hysteresis_tenths};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotate_threshold_dps     <= 12'd30;
      cfg_q.max_turn_dps             <= 13'd1200;
      cfg_q.quiet_ms                 <= 16'd250;
      cfg_q.min_announce_interval_ms <= 16'd300;
      cfg_q.settle_ms                <= 16'd500;
      cfg_q.hysteresis_tenths        <= 8'd50;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* sv/hsa_rate.sv */
// Turn rate compare of the current against the previous heading sample.
module hsa_rate
  import hsa_pkg::*;
(
  input  logic [HEAD_BITS-1:0] heading_i,
  input  logic [HEAD_BITS-1:0] prev_heading_i,
  input  tstamp_t              now_i,
  input  tstamp_t              prev_time_i,
  input  cfg_t                 cfg_i,
  output rate_t                rate_o
);

  localparam int unsigned PROD_BITS = TIME_BITS + 13;

  tstamp_t                dt;
  logic [SCALED_BITS-1:0] scaled;
  logic [PROD_BITS-1:0]   prod_thr;
  logic [PROD_BITS-1:0]   prod_max;
  logic [PROD_BITS-1:0]   scaled_ext;

  assign dt         = now_i - prev_time_i;
  assign scaled     = SCALED_BITS'(abs_delta(heading_i, prev_heading_i)) * RATE_SCALE;
  assign scaled_ext = PROD_BITS'(scaled);
  assign prod_thr   = PROD_BITS'(cfg_i.rotate_threshold_dps) * PROD_BITS'(dt);
  assign prod_max   = PROD_BITS'(cfg_i.max_turn_dps) * PROD_BITS'(dt);

  // The angle times 100 stands against the rate limit times the elapsed milliseconds.
  assign rate_o.dt_nonzero = (dt != '0);
  assign rate_o.jump       = (scaled_ext > prod_max);
  assign rate_o.rate_high  = (prod_thr <= scaled_ext);

endmodule

/* sv/hsa_core.sv */
// Sector tracking state, announce decision and result register.
module hsa_core
  import hsa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  item_t      item_i,
  input  cfg_t       cfg_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic       speak_o,
  output logic [2:0] sector_o,
  output logic [2:0] reason_o
);

  logic                   anchored_q, anchored_d;
  logic [2:0]             spoken_sector_q, spoken_sector_d;
  logic [2:0]             pending_sector_q, pending_sector_d;
  tstamp_t                change_time_q, change_time_d;
  tstamp_t                spoken_time_q, spoken_time_d;
  logic [HEAD_BITS-1:0]   prev_heading_q, prev_heading_d;
  logic                   prev_heading_valid_q, prev_heading_valid_d;
  tstamp_t                prev_time_q, prev_time_d;
  logic                   was_rotating_q, was_rotating_d;
  logic [LEADER_BITS-1:0] last_leader_q, last_leader_d;
  tstamp_t                jump_time_q, jump_time_d;
  logic                   muted_q, muted_d;

  logic       out_valid_q;
  logic       speak_q, speak_d;
  logic [2:0] sector_q, sector_d;
  logic [2:0] reason_q, reason_d;

  logic [HEAD_BITS-1:0] h;
  tstamp_t              now;
  logic [2:0]           raw_sector;
  rate_t                rate;
  logic                 have_rate, jumped, disc, rotating, stopped;
  logic [2:0]           sticky, pend_new, sec;
  tstamp_t              change_eff, jump_eff;
  logic                 do_emit;
  logic [2:0]           emit_reason;

  assign h          = (item_i.heading >= FULL_TURN) ? (item_i.heading - FULL_TURN)
                                                    : item_i.heading;
  assign now        = item_i.time_ms;
  assign raw_sector = sector_of(h);

  hsa_rate u_rate (
    .heading_i      (h),
    .prev_heading_i (prev_heading_q),
    .now_i          (now),
    .prev_time_i    (prev_time_q),
    .cfg_i          (cfg_i),
    .rate_o         (rate)
  );

  always_comb begin
    anchored_d           = anchored_q;
    spoken_sector_d      = spoken_sector_q;
    pending_sector_d     = pending_sector_q;
    change_time_d        = change_time_q;
    spoken_time_d        = spoken_time_q;
    prev_heading_d       = prev_heading_q;
    prev_heading_valid_d = prev_heading_valid_q;
    prev_time_d          = prev_time_q;
    was_rotating_d       = was_rotating_q;
    last_leader_d        = last_leader_q;
    jump_time_d          = jump_time_q;
    muted_d              = muted_q;

    have_rate   = prev_heading_valid_q & rate.dt_nonzero;
    jumped      = have_rate & rate.jump;
    disc        = (item_i.leader_id != last_leader_q) | jumped;
    rotating    = !disc && (have_rate ? rate.rate_high : was_rotating_q);
    stopped     = !disc && was_rotating_q && !rotating;
    jump_eff    = disc ? now : jump_time_q;
    sticky      = (abs_delta(h, sector_center(spoken_sector_q)) <=
                   DELTA_BITS'(SECTOR_HALF) + DELTA_BITS'(cfg_i.hysteresis_tenths))
                  ? spoken_sector_q : raw_sector;
    pend_new    = sticky;
    change_eff  = (sticky != pending_sector_q) ? now : change_time_q;
    sec         = stopped ? raw_sector : pend_new;
    do_emit     = 1'b0;
    emit_reason = REASON_NONE;

    if (item_i.kind) begin
      sec = raw_sector;
      if (item_i.heading_valid && !item_i.cinematic_active) begin
        if (!(anchored_q && (raw_sector == spoken_sector_q) &&
              ((now - spoken_time_q) < TIME_BITS'(item_i.dedup_window_ms)))) begin
          do_emit     = 1'b1;
          emit_reason = REASON_FACING;
        end
      end
    end else if (!item_i.heading_valid) begin
      anchored_d           = 1'b0;
      pending_sector_d     = 3'd0;
      prev_heading_valid_d = 1'b0;
      muted_d              = 1'b0;
      last_leader_d        = '0;
      jump_time_d          = '0;
    end else if (item_i.cinematic_active) begin
      muted_d = 1'b1;
    end else if (muted_q || (!item_i.auto_orient_active && !anchored_q)) begin
      muted_d              = 1'b0;
      anchored_d           = 1'b1;
      spoken_sector_d      = raw_sector;
      pending_sector_d     = raw_sector;
      change_time_d        = now;
      spoken_time_d        = now;
      was_rotating_d       = 1'b0;
      prev_heading_valid_d = 1'b0;
      last_leader_d        = item_i.leader_id;
      jump_time_d          = '0;
    end else if (item_i.auto_orient_active) begin
      was_rotating_d       = 1'b0;
      prev_heading_valid_d = 1'b0;
    end else begin
      if (!prev_heading_valid_q || rate.dt_nonzero) begin
        prev_heading_valid_d = 1'b1;
        prev_heading_d       = h;
        prev_time_d          = now;
      end
      last_leader_d    = item_i.leader_id;
      jump_time_d      = jump_eff;
      was_rotating_d   = rotating;
      pending_sector_d = pend_new;
      change_time_d    = change_eff;
      if (sec != spoken_sector_q) begin
        if ((jump_eff != '0) && ((now - jump_eff) < TIME_BITS'(cfg_i.settle_ms))) begin
          do_emit = 1'b0;
        end else if (stopped) begin
          do_emit     = 1'b1;
          emit_reason = REASON_STOPPED;
        end else if (rotating &&
                     ((now - spoken_time_q) >= TIME_BITS'(cfg_i.min_announce_interval_ms))) begin
          do_emit     = 1'b1;
          emit_reason = REASON_TURNING;
        end else if ((now - change_eff) >= TIME_BITS'(cfg_i.quiet_ms)) begin
          do_emit     = 1'b1;
          emit_reason = REASON_SETTLED;
        end
      end
    end

    if (do_emit) begin
      anchored_d       = 1'b1;
      spoken_sector_d  = sec;
      pending_sector_d = sec;
      change_time_d    = now;
      spoken_time_d    = now;
    end

    speak_d  = do_emit;
    sector_d = do_emit ? sec : 3'd0;
    reason_d = emit_reason;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchored_q           <= 1'b0;
      spoken_sector_q      <= 3'd0;
      pending_sector_q     <= 3'd0;
      change_time_q        <= '0;
      spoken_time_q        <= '0;
      prev_heading_q       <= '0;
      prev_heading_valid_q <= 1'b0;
      prev_time_q          <= '0;
      was_rotating_q       <= 1'b0;
      last_leader_q        <= '0;
      jump_time_q          <= '0;
      muted_q              <= 1'b0;
      out_valid_q          <= 1'b0;
    end else begin
      if (step_i) begin
        anchored_q           <= anchored_d;
        spoken_sector_q      <= spoken_sector_d;
        pending_sector_q     <= pending_sector_d;
        change_time_q        <= change_time_d;
        spoken_time_q        <= spoken_time_d;
        prev_heading_q       <= prev_heading_d;
        prev_heading_valid_q <= prev_heading_valid_d;
        prev_time_q          <= prev_time_d;
        was_rotating_q       <= was_rotating_d;
        last_leader_q        <= last_leader_d;
        jump_time_q          <= jump_time_d;
        muted_q              <= muted_d;
        out_valid_q          <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      speak_q  <= speak_d;
      sector_q <= sector_d;
      reason_q <= reason_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign speak_o     = speak_q;
  assign sector_o    = sector_q;
  assign reason_o    = reason_q;

endmodule
